@@ hw/rtl/lvm_pkg.sv @@
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared widths, column codes and defaults for the view matrix block.
// ----------------------------------------------------------------------------
package lvm_pkg;

	// Width of every coordinate and every matrix entry.
	localparam int COORD_W = 32;

	// Default number of fraction bits of the fixed-point format.
	localparam int FRAC_BITS_DEF = 16;

	// Column codes of the emitted matrix.
	typedef logic [1:0] col_t;
	localparam col_t FIRST_COL = 2'd0;
	localparam col_t LAST_COL  = 2'd3;

endpackage

@@ hw/rtl/lvm_cam_if.sv @@
// ----------------------------------------------------------------------------
// Camera setup channel
// Carries one eye point, target point and up vector per transfer.
// ----------------------------------------------------------------------------
interface lvm_cam_if;
	logic valid;
	logic ready;
	logic signed [lvm_pkg::COORD_W-1:0] eye_x;
	logic signed [lvm_pkg::COORD_W-1:0] eye_y;
	logic signed [lvm_pkg::COORD_W-1:0] eye_z;
	logic signed [lvm_pkg::COORD_W-1:0] target_x;
	logic signed [lvm_pkg::COORD_W-1:0] target_y;
	logic signed [lvm_pkg::COORD_W-1:0] target_z;
	logic signed [lvm_pkg::COORD_W-1:0] up_x;
	logic signed [lvm_pkg::COORD_W-1:0] up_y;
	logic signed [lvm_pkg::COORD_W-1:0] up_z;

	modport source (
		output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
		input  ready
	);
	modport sink (
		input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z,
		output ready
	);
endinterface

@@ hw/rtl/lvm_col_if.sv @@
// ----------------------------------------------------------------------------
// Matrix column channel
// Carries one column of the view matrix per transfer.
// ----------------------------------------------------------------------------
interface lvm_col_if;
	logic                               valid;
	logic                               ready;
	lvm_pkg::col_t                      column_index;
	logic signed [lvm_pkg::COORD_W-1:0] row0;
	logic signed [lvm_pkg::COORD_W-1:0] row1;
	logic signed [lvm_pkg::COORD_W-1:0] row2;
	logic signed [lvm_pkg::COORD_W-1:0] row3;
	logic                               last_column;
	logic                               degenerate;

	modport source (
		output valid, column_index, row0, row1, row2, row3, last_column, degenerate,
		input  ready
	);
	modport sink (
		input  valid, column_index, row0, row1, row2, row3, last_column, degenerate,
		output ready
	);
endinterface

@@ hw/rtl/lookat_view_matrix.sv @@
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the column-major 4x4 view matrix of a camera from its eye point,
// target point and up vector, all in signed fixed point.
// ----------------------------------------------------------------------------
//
//  Port   Direction  Transfer carries
//  -----  ---------  ---------------------------------------------------
//  cam    in         eye, target and up vectors of one camera setup
//  col    out        one matrix column; four per setup, column 0 first
//
// The pipeline takes a setup in any cycle its head is free, also before
// earlier setups are through; throughput is set by the single output port,
// which sends the four columns of each matrix one per transfer. Each of the
// two normalizers runs a 32-stage square root and a FRAC_BITS+1 stage divider.
// Reset clears all valid bits at once. A stall on col freezes the whole
// pipeline if its tail is full; nothing in flight is dropped or repeated.
// ----------------------------------------------------------------------------
module lookat_view_matrix #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lvm_cam_if.sink      cam,
	lvm_col_if.source    col
);

	localparam int CW   = lvm_pkg::COORD_W;
	localparam int UW   = FRAC_BITS + 2;       // unit vector component
	localparam int SPW  = UW + CW;             // side product
	localparam int SDW  = SPW + 1;             // side difference
	localparam int SMW  = FRAC_BITS + 33;      // side magnitude
	localparam int CRW  = 2 * UW;              // up' product
	localparam int URW  = CRW + 1;             // up' difference
	localparam int UUW  = URW - FRAC_BITS;     // rounded up' component
	localparam int DPW  = UW + CW;             // dot product term
	localparam int DW   = DPW + 2;             // dot sum
	localparam int TW   = DW - FRAC_BITS;      // rounded dot
	localparam int PUW  = UUW + CW;            // up' dot term
	localparam int EW   = PUW + 2;             // up' dot sum
	localparam int TUW  = EW - FRAC_BITS;      // rounded up' dot
	localparam int SATW = 48;

	localparam logic [URW-1:0] HALF_U = URW'(1) << (FRAC_BITS - 1);
	localparam logic [DW-1:0]  HALF_D = DW'(1) << (FRAC_BITS - 1);
	localparam logic [EW-1:0]  HALF_E = EW'(1) << (FRAC_BITS - 1);
	localparam logic [CW-1:0]  ONE    = CW'(1) << FRAC_BITS;

	typedef struct packed {
		logic [2:0][CW-1:0] eye;
		logic [2:0][CW-1:0] up;
	} sba_t;

	typedef struct packed {
		logic [2:0][CW-1:0] eye;
		logic [2:0][UW-1:0] fn;
		logic               za;
	} sbb_t;

	// Saturate a wide signed value to the coordinate range.
	function automatic logic [CW-1:0] sat32(input logic signed [SATW-1:0] x);
		logic [CW-1:0] r;
		if (x > SATW'(signed'(32'sh7fffffff))) begin
			r = 32'h7fffffff;
		end else if (x < SATW'(signed'(-33'sh80000000))) begin
			r = 32'h80000000;
		end else begin
			r = x[CW-1:0];
		end
		return r;
	endfunction

	logic en;
	logic tail_v;
	logic load_ok;

	// Stage 1: forward vector and its magnitude.
	logic signed [CW-1:0] eye_c [3];
	logic signed [CW-1:0] tgt_c [3];
	logic signed [CW-1:0] up_c  [3];
	logic signed [CW:0]   fw_c  [3];

	logic                 v_s1;
	logic [2:0][CW:0]     fmag_s1;
	logic [2:0]           fneg_s1;
	sba_t                 sba_s1;

	assign eye_c[0] = cam.eye_x;
	assign eye_c[1] = cam.eye_y;
	assign eye_c[2] = cam.eye_z;
	assign tgt_c[0] = cam.target_x;
	assign tgt_c[1] = cam.target_y;
	assign tgt_c[2] = cam.target_z;
	assign up_c[0]  = cam.up_x;
	assign up_c[1]  = cam.up_y;
	assign up_c[2]  = cam.up_z;

	assign cam.ready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fw_c[i] = (CW+1)'(tgt_c[i]) - (CW+1)'(eye_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cam.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				fmag_s1[i]    <= fw_c[i][CW] ? (CW+1)'(-fw_c[i]) : (CW+1)'(fw_c[i]);
				fneg_s1[i]    <= fw_c[i][CW];
				sba_s1.eye[i] <= eye_c[i];
				sba_s1.up[i]  <= up_c[i];
			end
		end
	end

	// Normalize the forward vector.
	logic                    va;
	logic [2:0][UW-1:0]      fn_a;
	logic                    za;
	logic [$bits(sba_t)-1:0] sb_a_raw;
	sba_t                    sb_a;

	lvm_unit3 #(
		.FRAC_BITS (FRAC_BITS),
		.MW        (CW + 1),
		.SB_W      ($bits(sba_t))
	) u_norm_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_mag    (fmag_s1),
		.in_neg    (fneg_s1),
		.in_sb     (sba_s1),
		.out_valid (va),
		.out_unit  (fn_a),
		.out_zero  (za),
		.out_sb    (sb_a_raw)
	);

	assign sb_a = sba_t'(sb_a_raw);

	// Stage 2: side products fn x up.
	logic                  v_s2;
	logic signed [SPW-1:0] sp_s2 [6];
	sbb_t                  sbb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= va;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sp_s2[0] <= $signed(fn_a[1]) * $signed(sb_a.up[2]);
			sp_s2[1] <= $signed(fn_a[2]) * $signed(sb_a.up[1]);
			sp_s2[2] <= $signed(fn_a[2]) * $signed(sb_a.up[0]);
			sp_s2[3] <= $signed(fn_a[0]) * $signed(sb_a.up[2]);
			sp_s2[4] <= $signed(fn_a[0]) * $signed(sb_a.up[1]);
			sp_s2[5] <= $signed(fn_a[1]) * $signed(sb_a.up[0]);
			sbb_s2.eye <= sb_a.eye;
			sbb_s2.fn  <= fn_a;
			sbb_s2.za  <= za;
		end
	end

	// Stage 3: side differences.
	logic                  v_s3;
	logic signed [SDW-1:0] sd_s3 [3];
	sbb_t                  sbb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sd_s3[i] <= SDW'(sp_s2[2*i]) - SDW'(sp_s2[2*i+1]);
			end
			sbb_s3 <= sbb_s2;
		end
	end

	// Stage 4: side magnitudes.
	logic                  v_s4;
	logic [2:0][SMW-1:0]   smag_s4;
	logic [2:0]            sneg_s4;
	sbb_t                  sbb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				smag_s4[i] <= sd_s3[i][SDW-1] ? SMW'(-sd_s3[i]) : SMW'(sd_s3[i]);
				sneg_s4[i] <= sd_s3[i][SDW-1];
			end
			sbb_s4 <= sbb_s3;
		end
	end

	// Normalize the side vector.
	logic                    vb;
	logic [2:0][UW-1:0]      sn_b;
	logic                    zb;
	logic [$bits(sbb_t)-1:0] sb_b_raw;
	sbb_t                    sb_b;

	lvm_unit3 #(
		.FRAC_BITS (FRAC_BITS),
		.MW        (SMW),
		.SB_W      ($bits(sbb_t))
	) u_norm_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_mag    (smag_s4),
		.in_neg    (sneg_s4),
		.in_sb     (sbb_s4),
		.out_valid (vb),
		.out_unit  (sn_b),
		.out_zero  (zb),
		.out_sb    (sb_b_raw)
	);

	assign sb_b = sbb_t'(sb_b_raw);

	// Stage 5: up' products and dot product terms.
	logic                  v_s5;
	logic                  degen_s5;
	logic signed [CRW-1:0] cr_s5 [6];
	logic signed [DPW-1:0] ds_s5 [3];
	logic signed [DPW-1:0] df_s5 [3];
	logic signed [UW-1:0]  sn_s5 [3];
	logic signed [UW-1:0]  fn_s5 [3];
	logic signed [CW-1:0]  eye_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s5[0] <= $signed(sn_b[1]) * $signed(sb_b.fn[2]);
			cr_s5[1] <= $signed(sn_b[2]) * $signed(sb_b.fn[1]);
			cr_s5[2] <= $signed(sn_b[2]) * $signed(sb_b.fn[0]);
			cr_s5[3] <= $signed(sn_b[0]) * $signed(sb_b.fn[2]);
			cr_s5[4] <= $signed(sn_b[0]) * $signed(sb_b.fn[1]);
			cr_s5[5] <= $signed(sn_b[1]) * $signed(sb_b.fn[0]);
			for (int i = 0; i < 3; i++) begin
				ds_s5[i]  <= $signed(sn_b[i]) * $signed(sb_b.eye[i]);
				df_s5[i]  <= $signed(sb_b.fn[i]) * $signed(sb_b.eye[i]);
				sn_s5[i]  <= $signed(sn_b[i]);
				fn_s5[i]  <= $signed(sb_b.fn[i]);
				eye_s5[i] <= $signed(sb_b.eye[i]);
			end
			degen_s5 <= sb_b.za | zb;
		end
	end

	// Stage 6: up' differences and dot sums.
	logic                  v_s6;
	logic                  degen_s6;
	logic signed [URW-1:0] ur_s6 [3];
	logic signed [DW-1:0]  dss_s6;
	logic signed [DW-1:0]  dfs_s6;
	logic signed [UW-1:0]  sn_s6 [3];
	logic signed [UW-1:0]  fn_s6 [3];
	logic signed [CW-1:0]  eye_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ur_s6[i] <= URW'(cr_s5[2*i]) - URW'(cr_s5[2*i+1]);
			end
			dss_s6   <= DW'(ds_s5[0]) + DW'(ds_s5[1]) + DW'(ds_s5[2]);
			dfs_s6   <= DW'(df_s5[0]) + DW'(df_s5[1]) + DW'(df_s5[2]);
			sn_s6    <= sn_s5;
			fn_s6    <= fn_s5;
			eye_s6   <= eye_s5;
			degen_s6 <= degen_s5;
		end
	end

	// Stage 7: round half away from zero. Adding one less than half for a
	// negative value and shifting arithmetically gives the same result.
	logic                  v_s7;
	logic                  degen_s7;
	logic signed [UUW-1:0] uu_s7 [3];
	logic signed [TW-1:0]  ts_s7;
	logic signed [TW-1:0]  tf_s7;
	logic signed [UW-1:0]  sn_s7 [3];
	logic signed [UW-1:0]  fn_s7 [3];
	logic signed [CW-1:0]  eye_s7 [3];
	logic [URW-1:0]        ur_rnd_c [3];
	logic [DW-1:0]         ts_rnd_c;
	logic [DW-1:0]         tf_rnd_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ur_rnd_c[i] = ur_s6[i] + HALF_U - URW'(ur_s6[i][URW-1]);
		end
		ts_rnd_c = dss_s6 + HALF_D - DW'(dss_s6[DW-1]);
		tf_rnd_c = dfs_s6 + HALF_D - DW'(dfs_s6[DW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				uu_s7[i] <= $signed(ur_rnd_c[i][URW-1:FRAC_BITS]);
			end
			ts_s7    <= $signed(ts_rnd_c[DW-1:FRAC_BITS]);
			tf_s7    <= $signed(tf_rnd_c[DW-1:FRAC_BITS]);
			sn_s7    <= sn_s6;
			fn_s7    <= fn_s6;
			eye_s7   <= eye_s6;
			degen_s7 <= degen_s6;
		end
	end

	// Stage 8: up' dot terms; saturate the side and forward translations.
	logic                  v_s8;
	logic                  degen_s8;
	logic signed [PUW-1:0] pu_s8 [3];
	logic [CW-1:0]         t0_s8;
	logic [CW-1:0]         t2_s8;
	logic signed [UUW-1:0] uu_s8 [3];
	logic signed [UW-1:0]  sn_s8 [3];
	logic signed [UW-1:0]  fn_s8 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pu_s8[i] <= uu_s7[i] * eye_s7[i];
			end
			t0_s8    <= sat32(-SATW'(ts_s7));
			t2_s8    <= sat32(SATW'(tf_s7));
			uu_s8    <= uu_s7;
			sn_s8    <= sn_s7;
			fn_s8    <= fn_s7;
			degen_s8 <= degen_s7;
		end
	end

	// Stage 9: up' dot sum.
	logic                  v_s9;
	logic                  degen_s9;
	logic signed [EW-1:0]  su_s9;
	logic [CW-1:0]         t0_s9;
	logic [CW-1:0]         t2_s9;
	logic signed [UUW-1:0] uu_s9 [3];
	logic signed [UW-1:0]  sn_s9 [3];
	logic signed [UW-1:0]  fn_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			su_s9    <= EW'(pu_s8[0]) + EW'(pu_s8[1]) + EW'(pu_s8[2]);
			t0_s9    <= t0_s8;
			t2_s9    <= t2_s8;
			uu_s9    <= uu_s8;
			sn_s9    <= sn_s8;
			fn_s9    <= fn_s8;
			degen_s9 <= degen_s8;
		end
	end

	// Stage 10: round the up' dot.
	logic                  v_s10;
	logic                  degen_s10;
	logic signed [TUW-1:0] tu_s10;
	logic [CW-1:0]         t0_s10;
	logic [CW-1:0]         t2_s10;
	logic signed [UUW-1:0] uu_s10 [3];
	logic signed [UW-1:0]  sn_s10 [3];
	logic signed [UW-1:0]  fn_s10 [3];
	logic [EW-1:0]         su_rnd_c;

	assign su_rnd_c = su_s9 + HALF_E - EW'(su_s9[EW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tu_s10    <= $signed(su_rnd_c[EW-1:FRAC_BITS]);
			t0_s10    <= t0_s9;
			t2_s10    <= t2_s9;
			uu_s10    <= uu_s9;
			sn_s10    <= sn_s9;
			fn_s10    <= fn_s9;
			degen_s10 <= degen_s9;
		end
	end

	// Stage 11: saturate the up' translation.
	logic                  v_s11;
	logic                  degen_s11;
	logic [CW-1:0]         t0_s11;
	logic [CW-1:0]         t1_s11;
	logic [CW-1:0]         t2_s11;
	logic signed [UUW-1:0] uu_s11 [3];
	logic signed [UW-1:0]  sn_s11 [3];
	logic signed [UW-1:0]  fn_s11 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s11    <= sat32(-SATW'(tu_s10));
			t0_s11    <= t0_s10;
			t2_s11    <= t2_s10;
			uu_s11    <= uu_s10;
			sn_s11    <= sn_s10;
			fn_s11    <= fn_s10;
			degen_s11 <= degen_s10;
		end
	end

	assign tail_v = v_s11;

	// Assemble the four columns of the finished matrix; all zero if degenerate.
	logic [CW-1:0] mat_c [4][4];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mat_c[c][0] = CW'(sn_s11[c]);
			mat_c[c][1] = CW'(uu_s11[c]);
			mat_c[c][2] = -CW'(fn_s11[c]);
			mat_c[c][3] = '0;
		end
		mat_c[3][0] = t0_s11;
		mat_c[3][1] = t1_s11;
		mat_c[3][2] = t2_s11;
		mat_c[3][3] = ONE;
		if (degen_s11) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					mat_c[c][r] = '0;
				end
			end
		end
	end

	// Column sender: holds one matrix and sends a column per transfer.
	// A new matrix loads in the cycle the last column goes out.
	logic [CW-1:0]  mat_q [4][4];
	logic           degen_q;
	lvm_pkg::col_t  col_q;
	logic           busy_q;
	logic           load;

	assign load_ok = !busy_q || (col.ready && col_q == lvm_pkg::LAST_COL);
	assign en      = !tail_v || load_ok;
	assign load    = tail_v && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= lvm_pkg::FIRST_COL;
		end else begin
			if (busy_q && col.ready) begin
				col_q <= col_q + 2'd1;
				if (col_q == lvm_pkg::LAST_COL) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				busy_q <= 1'b1;
				col_q  <= lvm_pkg::FIRST_COL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mat_q   <= mat_c;
			degen_q <= degen_s11;
		end
	end

	assign col.valid        = busy_q;
	assign col.column_index = col_q;
	assign col.row0         = mat_q[col_q][0];
	assign col.row1         = mat_q[col_q][1];
	assign col.row2         = mat_q[col_q][2];
	assign col.row3         = mat_q[col_q][3];
	assign col.last_column  = (col_q == lvm_pkg::LAST_COL);
	assign col.degenerate   = degen_q;

endmodule

@@ hw/rtl/lvm_unit3.sv @@
// ----------------------------------------------------------------------------
// Pipelined vector normalizer
// Scales three magnitudes so the largest lies in [2^29, 2^30), takes the
// floor square root of the sum of squares one result bit per stage, then
// divides each component by that length one quotient bit per stage.
// ----------------------------------------------------------------------------
module lvm_unit3 #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
	parameter int MW        = 33,
	parameter int SB_W      = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [2:0][MW-1:0]       in_mag,
	input  logic [2:0]               in_neg,
	input  logic [SB_W-1:0]          in_sb,
	output logic                     out_valid,
	output logic [2:0][FRAC_BITS+1:0] out_unit,
	output logic                     out_zero,
	output logic [SB_W-1:0]          out_sb
);

	localparam int PW       = $clog2(MW);
	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = FRAC_BITS + 1;
	localparam int QW       = FRAC_BITS + 1;
	localparam int UW       = FRAC_BITS + 2;

	typedef struct packed {
		logic [61:0]       n;
		logic [62:0]       r;
		logic [2:0][29:0]  sc;
		logic [2:0]        neg;
		logic              zero;
		logic [SB_W-1:0]   sb;
	} sq_t;

	typedef struct packed {
		logic [2:0][31:0]  r;
		logic [2:0][QW-1:0] q;
		logic [30:0]       len;
		logic [2:0]        neg;
		logic              zero;
		logic [SB_W-1:0]   sb;
	} dv_t;

	// Position of the leading one of a magnitude.
	function automatic logic [PW-1:0] lead_one(input logic [MW-1:0] x);
		logic [PW-1:0] p;
		p = '0;
		for (int i = 0; i < MW; i++) begin
			if (x[i]) begin
				p = PW'(i);
			end
		end
		return p;
	endfunction

	// Stage 1: largest magnitude.
	logic                 v_s1;
	logic [2:0][MW-1:0]   m_s1;
	logic [MW-1:0]        top_s1;
	logic [2:0]           neg_s1;
	logic [SB_W-1:0]      sb_s1;
	logic [MW-1:0]        top01_c;
	logic [MW-1:0]        top_c;

	always_comb begin
		top01_c = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
		top_c   = (top01_c > in_mag[2]) ? top01_c : in_mag[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= in_mag;
			top_s1 <= top_c;
			neg_s1 <= in_neg;
			sb_s1  <= in_sb;
		end
	end

	// Stage 2: leading-one position and zero test.
	logic                 v_s2;
	logic [2:0][MW-1:0]   m_s2;
	logic [PW-1:0]        p_s2;
	logic                 zero_s2;
	logic [2:0]           neg_s2;
	logic [SB_W-1:0]      sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2    <= m_s1;
			p_s2    <= lead_one(top_s1);
			zero_s2 <= (top_s1 == '0);
			neg_s2  <= neg_s1;
			sb_s2   <= sb_s1;
		end
	end

	// Stage 3: scale so the leading one of the largest lands on bit 29.
	// Shifting m * 2^29 right by the position covers both directions and
	// truncates when the scale is a right shift.
	logic                 v_s3;
	logic [2:0][29:0]     sc_s3;
	logic                 zero_s3;
	logic [2:0]           neg_s3;
	logic [SB_W-1:0]      sb_s3;
	logic [2:0][29:0]     sc_c;
	logic [MW+28:0]       ext_c;

	always_comb begin
		ext_c = '0;
		for (int i = 0; i < 3; i++) begin
			ext_c   = {m_s2[i], 29'b0} >> p_s2;
			sc_c[i] = ext_c[29:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s3   <= sc_c;
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			sb_s3   <= sb_s2;
		end
	end

	// Stage 4: squares.
	logic                 v_s4;
	logic [2:0][59:0]     sqr_s4;
	logic [2:0][29:0]     sc_s4;
	logic                 zero_s4;
	logic [2:0]           neg_s4;
	logic [SB_W-1:0]      sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqr_s4[i] <= 60'(sc_s3[i]) * 60'(sc_s3[i]);
			end
			sc_s4   <= sc_s3;
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			sb_s4   <= sb_s3;
		end
	end

	// Stage 5: sum of squares, start of the square root.
	logic v_s5;
	sq_t  sq0_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq0_s5.n    <= 62'(sqr_s4[0]) + 62'(sqr_s4[1]) + 62'(sqr_s4[2]);
			sq0_s5.r    <= '0;
			sq0_s5.sc   <= sc_s4;
			sq0_s5.neg  <= neg_s4;
			sq0_s5.zero <= zero_s4;
			sq0_s5.sb   <= sb_s4;
		end
	end

	// Square root: one result bit per stage, from 2^62 down to 2^0.
	logic sq_v_s [1:SQ_STEPS];
	sq_t  sq_s   [1:SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
		sq_t        cur;
		sq_t        nxt;
		logic       cur_v;
		logic [62:0] trial;

		if (k == 0) begin : g_first
			assign cur   = sq0_s5;
			assign cur_v = v_s5;
		end else begin : g_next
			assign cur   = sq_s[k];
			assign cur_v = sq_v_s[k];
		end

		always_comb begin
			nxt   = cur;
			trial = cur.r + BIT;
			if ({1'b0, cur.n} >= trial) begin
				nxt.n = 62'({1'b0, cur.n} - trial);
				nxt.r = (cur.r >> 1) + BIT;
			end else begin
				nxt.r = cur.r >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// Division: one quotient bit per stage, MSB (worth one) first.
	logic dv_v_s [1:DV_STEPS];
	dv_t  dv_s   [1:DV_STEPS];
	dv_t  dv_init;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_init.r[i] = 32'(sq_s[SQ_STEPS].sc[i]);
			dv_init.q[i] = '0;
		end
		dv_init.len  = sq_s[SQ_STEPS].r[30:0];
		dv_init.neg  = sq_s[SQ_STEPS].neg;
		dv_init.zero = sq_s[SQ_STEPS].zero;
		dv_init.sb   = sq_s[SQ_STEPS].sb;
	end

	for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
		dv_t        cur;
		dv_t        nxt;
		logic       cur_v;
		logic [2:0] ge;
		logic [31:0] rem;

		if (k == 0) begin : g_first
			assign cur   = dv_init;
			assign cur_v = sq_v_s[SQ_STEPS];
		end else begin : g_next
			assign cur   = dv_s[k];
			assign cur_v = dv_v_s[k];
		end

		always_comb begin
			nxt = cur;
			rem = '0;
			for (int i = 0; i < 3; i++) begin
				ge[i]     = (cur.r[i] >= {1'b0, cur.len});
				rem       = ge[i] ? (cur.r[i] - {1'b0, cur.len}) : cur.r[i];
				nxt.r[i]  = rem << 1;
				nxt.q[i]  = {cur.q[i][QW-2:0], ge[i]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// Output stage: restore the signs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v_s[DV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				out_unit[i] <= dv_s[DV_STEPS].neg[i] ? UW'(-{1'b0, dv_s[DV_STEPS].q[i]})
				                                     : UW'({1'b0, dv_s[DV_STEPS].q[i]});
			end
			out_zero <= dv_s[DV_STEPS].zero;
			out_sb   <= dv_s[DV_STEPS].sb;
		end
	end

endmodule

@@ tb/sv/lvm_tb_if.sv @@
// ----------------------------------------------------------------------------
// View matrix testbench channels
// Testbench-side note: the block's channels are the RTL interfaces
// lvm_cam_if and lvm_col_if, instantiated directly in the testbench top.
// ----------------------------------------------------------------------------
package lvm_tb_pkg;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected matrix column.
	typedef struct {
		logic [1:0]  column_index;
		logic [31:0] row0;
		logic [31:0] row1;
		logic [31:0] row2;
		logic [31:0] row3;
		logic        last_column;
		logic        degenerate;
	} column_t;
endpackage

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Look-at view matrix testbench
// Drives camera setups, predicts the four view matrix columns of each in
// fixed point and compares every column transfer with the prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lvm_pkg::*;
	import lvm_tb_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lvm_cam_if cam ();
	lvm_col_if col ();

	lookat_view_matrix #(.FRAC_BITS(FB)) i_dut (
		.clk(clk), .arst_n(arst_n), .cam(cam.sink), .col(col.source)
	);

	always #6 clk = ~clk;

	column_t expected_columns[$];
	int mismatches = 0;
	int columns_seen = 0;
	int setups_sent = 0;
	int degenerate_seen = 0;
	int idle_cycles = 0;
	bit rx_random = 1'b1;

	// Square root, rounded down.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] magnitude(input longint x);
		return x < 0 ? 64'd0 - 64'(x) : 64'(x);
	endfunction

	// Scale to a unit vector; returns 0 for a zero vector.
	function automatic bit normalize(input longint v[3], output longint u[3]);
		logic [63:0] m[3];
		logic [63:0] top, total, len;
		int lsh, rsh;
		top = 0; total = 0; lsh = 0; rsh = 0;
		u = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			m[i] = magnitude(v[i]);
			if (m[i] > top) top = m[i];
		end
		if (top == 0) return 1'b0;
		while ((top << lsh) < (64'd1 << 29)) lsh++;
		while ((top >> rsh) >= (64'd1 << 30)) rsh++;
		for (int i = 0; i < 3; i++) begin
			m[i] = lsh != 0 ? (m[i] << lsh) : (m[i] >> rsh);
			total += m[i] * m[i];
		end
		len = floor_sqrt(total);
		for (int i = 0; i < 3; i++) begin
			u[i] = longint'((m[i] << FB) / len);
			if (v[i] < 0) u[i] = -u[i];
		end
		return 1'b1;
	endfunction

	// Drop the fraction bits, rounding half away from zero.
	function automatic longint round_frac(input longint x);
		logic [63:0] m;
		m = (magnitude(x) + (64'd1 << (FB - 1))) >> FB;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp32(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Work out the four columns of one camera setup and queue them.
	function automatic void predict_view_matrix(input logic signed [31:0] p[9]);
		longint eye[3], tgt[3], upv[3], fwd[3], fn[3], sd[3], sn[3], uu[3];
		longint m[16];
		bit degen;
		column_t c;
		degen = 1'b0;
		sn = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			eye[i] = p[i]; tgt[i] = p[3 + i]; upv[i] = p[6 + i];
			fwd[i] = tgt[i] - eye[i];
		end
		for (int i = 0; i < 16; i++) m[i] = 0;
		if (!normalize(fwd, fn)) begin
			degen = 1'b1;
		end else begin
			sd[0] = fn[1] * upv[2] - fn[2] * upv[1];
			sd[1] = fn[2] * upv[0] - fn[0] * upv[2];
			sd[2] = fn[0] * upv[1] - fn[1] * upv[0];
			if (!normalize(sd, sn)) degen = 1'b1;
		end
		if (!degen) begin
			uu[0] = round_frac(sn[1] * fn[2] - sn[2] * fn[1]);
			uu[1] = round_frac(sn[2] * fn[0] - sn[0] * fn[2]);
			uu[2] = round_frac(sn[0] * fn[1] - sn[1] * fn[0]);
			for (int k = 0; k < 3; k++) begin
				m[k * 4] = sn[k]; m[k * 4 + 1] = uu[k]; m[k * 4 + 2] = -fn[k];
			end
			m[12] = clamp32(-round_frac(sn[0] * eye[0] + sn[1] * eye[1] + sn[2] * eye[2]));
			m[13] = clamp32(-round_frac(uu[0] * eye[0] + uu[1] * eye[1] + uu[2] * eye[2]));
			m[14] = clamp32(round_frac(fn[0] * eye[0] + fn[1] * eye[1] + fn[2] * eye[2]));
			m[15] = longint'(1) << FB;
		end
		for (int k = 0; k < 4; k++) begin
			c.column_index = col_t'(k);
			c.row0 = m[k * 4][31:0];
			c.row1 = m[k * 4 + 1][31:0];
			c.row2 = m[k * 4 + 2][31:0];
			c.row3 = m[k * 4 + 3][31:0];
			c.last_column = (col_t'(k) == LAST_COL);
			c.degenerate = degen;
			expected_columns = {expected_columns, c};
		end
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Send one camera setup and wait for its transfer. Valid stays high
	// after the transfer so that the next setup can follow without a gap.
	task automatic send_setup(input logic signed [31:0] p[9], input bit idle);
		int g;
		g = idle ? gap_length() : 0;
		if (g > 0) begin
			cam.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cam.valid <= 1'b1;
		{cam.eye_x, cam.eye_y, cam.eye_z} <= {p[0], p[1], p[2]};
		{cam.target_x, cam.target_y, cam.target_z} <= {p[3], p[4], p[5]};
		{cam.up_x, cam.up_y, cam.up_z} <= {p[6], p[7], p[8]};
		do @(posedge clk); while (!cam.ready);
		predict_view_matrix(p);
		setups_sent++;
	endtask

	// Stop sending and wait until every predicted column has come out.
	task automatic wait_drained();
		cam.valid <= 1'b0;
		while (expected_columns.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			1: return $signed($urandom_range(0, 20) << FB) - $signed(10 << FB);
			2: return $signed($urandom_range(0, 65535)) - 32768;
			default: return $urandom;
		endcase
	endfunction

	// Field extremes, zero forward, zero and parallel up, near-parallel up,
	// translation overflow.
	task automatic test_directed();
		logic signed [31:0] p[9];
		localparam logic signed [31:0] ONE = 32'sd1 << FB;
		localparam logic signed [31:0] MX = 32'sh7fffffff;
		localparam logic signed [31:0] MN = 32'sh80000000;
		p = '{0, 0, ONE * 5, 0, 0, 0, 0, ONE, 0}; send_setup(p, 1'b0);
		p = '{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0}; send_setup(p, 1'b0);
		p = '{0, 0, 0, ONE, 0, 0, 0, 0, 0}; send_setup(p, 1'b0);
		p = '{0, 0, 0, ONE, 0, 0, 3 * ONE, 0, 0}; send_setup(p, 1'b0);
		p = '{0, 0, 0, ONE, 0, 0, -ONE, 0, 0}; send_setup(p, 1'b0);
		p = '{0, 0, 0, MX, 0, 0, MX, 1, 0}; send_setup(p, 1'b0);
		p = '{0, 0, 0, 1, 0, 0, 0, 0, 1}; send_setup(p, 1'b0);
		p = '{MX, MX, MX, MN, MN, MN, 0, ONE, 0}; send_setup(p, 1'b0);
		p = '{MN, MN, MN, MX, MX, MX, MX, MN, 0}; send_setup(p, 1'b0);
		p = '{MN, MX, MN, 0, 0, 0, MN, MN, MX}; send_setup(p, 1'b0);
		p = '{MX, MN, MX, MX, MX, MN, MX, MX, MN}; send_setup(p, 1'b0);
		p = '{-1, -1, -1, 0, 0, 0, 0, 0, -1}; send_setup(p, 1'b0);
		p = '{32'sh55555555, 32'shaaaaaaaa, 0, 32'shaaaaaaaa, 32'sh55555555, 1,
			32'sh55555555, 32'shaaaaaaaa, 32'sh12345678}; send_setup(p, 1'b0);
		p = '{MX, 0, 0, 0, MX, 0, 0, 0, ONE}; send_setup(p, 1'b0);
		p = '{MN, 0, 0, MN, 0, ONE, 0, ONE, 0}; send_setup(p, 1'b0);
	endtask

	// Random setups: mixed coordinate styles, some degenerate on purpose.
	task automatic test_random(input int count);
		logic signed [31:0] p[9];
		int mode, kind;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 9; i++)
				p[i] = rand_coord($urandom_range(0, 9) == 0 ? 0 : mode);
			kind = $urandom_range(0, 19);
			if (kind == 0) p[3:5] = p[0:2];
			else if (kind == 1) p[6:8] = '{0, 0, 0};
			else if (kind == 2) for (int i = 0; i < 3; i++) p[6 + i] = p[3 + i] - p[i];
			send_setup(p, n % 50 < 40);
			if (n == count / 2) wait_drained();
		end
	endtask

	// Full-rate burst with the receiver always ready.
	task automatic test_back_to_back(input int count);
		logic signed [31:0] p[9];
		rx_random = 1'b0;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 9; i++) p[i] = rand_coord($urandom_range(1, 3));
			send_setup(p, 1'b0);
		end
		wait_drained();
		rx_random = 1'b1;
	endtask

	// Receiver ready with random stalls, or always ready in the back-to-back test.
	initial begin
		col.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_random && $urandom_range(0, 199) == 0) begin
				col.ready <= 1'b0;
				repeat ($urandom_range(10, 80)) @(posedge clk);
			end else if (!rx_random) begin
				col.ready <= 1'b1;
			end else begin
				col.ready <= ($urandom_range(0, 9) < 6) || ($urandom_range(0, 1) == 1);
			end
		end
	end

	// Compare each column transfer with the oldest prediction.
	always @(posedge clk) begin
		column_t e;
		if (arst_n && col.valid && col.ready) begin
			columns_seen++;
			if (col.degenerate === 1'b1 && col.last_column === 1'b1) degenerate_seen++;
			if (expected_columns.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected column transfer at %0t", $realtime);
			end else begin
				e = expected_columns.pop_front();
				if (col.column_index !== e.column_index || col.row0 !== e.row0 ||
					col.row1 !== e.row1 || col.row2 !== e.row2 || col.row3 !== e.row3 ||
					col.last_column !== e.last_column || col.degenerate !== e.degenerate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("column mismatch: exp %0d %h %h %h %h %b %b got %0d %h %h %h %h %b %b",
							e.column_index, e.row0, e.row1, e.row2, e.row3, e.last_column,
							e.degenerate, col.column_index, col.row0, col.row1, col.row2,
							col.row3, col.last_column, col.degenerate);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((cam.valid && cam.ready) || (col.valid && col.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL lookat_view_matrix");
			$finish;
		end
	end

	initial begin
		cam.valid = 1'b0;
		{cam.eye_x, cam.eye_y, cam.eye_z} = '0;
		{cam.target_x, cam.target_y, cam.target_z} = '0;
		{cam.up_x, cam.up_y, cam.up_z} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(215);
		test_back_to_back(30);
		repeat (2 * FB + 150) @(posedge clk);
		$display("Sent %0d camera setups, checked %0d columns, %0d degenerate matrices.",
			setups_sent, columns_seen, degenerate_seen);
		if (mismatches == 0 && expected_columns.size() == 0) begin
			$display("PASS lookat_view_matrix");
		end else begin
			$display("FAIL lookat_view_matrix");
		end
		$finish;
	end
endmodule
